>>> rtl/core/scac_pkg.sv
// Shared constants and controller/datapath handshake types for the sensor
// code converter and averager. No dependencies.
package scac_pkg;

   localparam int SAMPLES_DEF = 8;

   localparam int CODE_W    = 16;  // raw converter code
   localparam int VAL_W     = 16;  // converted value, signed Q8.8
   localparam int HVAL_W    = 15;  // humidity value, always non-negative
   localparam int COUNT_W   = 7;   // samples_used field

   localparam int TEMP_MUL  = 165;
   localparam int TEMP_OFS  = 40 * 256;
   localparam int HUMID_MUL = 100;

   localparam logic CH_TEMP  = 1'b0;
   localparam logic CH_HUMID = 1'b1;

   typedef struct packed {
      logic capture;   // latch the accepted item
      logic read;      // convert code, read the ring slot
      logic update;    // update ring and sum, load the divider
      logic div_step;  // one quotient bit
      logic out_load;  // move the quotient into the output register
   } scac_cmd_type;

   typedef struct packed {
      logic div_done;
   } scac_sts_type;

endpackage

>>> rtl/core/scac_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on scac_pkg for field widths.
interface scac_req_intf
   import scac_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              sensor_channel;
   logic [CODE_W-1:0] raw_code;

   modport source (output valid, sensor_channel, raw_code, input ready);
   modport sink   (input valid, sensor_channel, raw_code, output ready);
endinterface

interface scac_rsp_intf
   import scac_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     result_channel;
   logic signed [VAL_W-1:0]  average_value;
   logic [COUNT_W-1:0]       samples_used;

   modport source (output valid, result_channel, average_value, samples_used, input ready);
   modport sink   (input valid, result_channel, average_value, samples_used, output ready);
endinterface

>>> rtl/core/scac_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module scac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/scac_ctrl.sv
// Sequencing state machine: accept, convert/read, update, divide, output.
// Depends on scac_pkg for the command and status structs.
module scac_ctrl
   import scac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output scac_cmd_type cmd,
   input  scac_sts_type sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_DIV  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!sts.div_done) begin
               cmd.div_step = 1'b1;
            end else if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted item did not start processing");

   a_upd_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> (state_ff == ST_DIV && !req_ready))
      else $error("update not followed by divide");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_valid && req_ready))
      else $error("loaded result not presented");

endmodule

>>> rtl/core/scac_datapath.sv
// Conversion, per-channel ring buffers with running sums, and a
// bit-per-cycle divider. Depends on scac_pkg and scac_ram.
module scac_datapath
   import scac_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scac_cmd_type             cmd,
   output scac_sts_type             sts,
   input  logic                     req_sensor_channel,
   input  logic [CODE_W-1:0]        req_raw_code,
   output logic                     rsp_result_channel,
   output logic signed [VAL_W-1:0]  rsp_average_value,
   output logic [COUNT_W-1:0]       rsp_samples_used
);

   localparam int LOG_S  = $clog2(SAMPLES);
   localparam int IDX_W  = (SAMPLES > 1) ? LOG_S : 1;
   localparam int CNT_W  = $clog2(SAMPLES + 1);
   localparam int TSUM_W = VAL_W + LOG_S;
   localparam int HSUM_W = HVAL_W + LOG_S;
   localparam int MAG_W  = TSUM_W;
   localparam int STEP_W = $clog2(MAG_W + 1);
   localparam int DEPTH  = 2 * SAMPLES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TPROD_W = CODE_W + 8;
   localparam int HPROD_W = CODE_W + 7;

   // captured item and converted value
   logic                     chan_ff;
   logic [CODE_W-1:0]        code_ff;
   logic signed [VAL_W-1:0]  value_ff, value_in;

   // per-channel ring state
   logic [IDX_W-1:0]         tidx_ff, hidx_ff;
   logic                     tfill_ff, hfill_ff;
   logic signed [TSUM_W-1:0] tsum_ff, tsum_in;
   logic [HSUM_W-1:0]        hsum_ff, hsum_in;

   // divider
   logic [MAG_W-1:0]         dvd_ff, dvd_in, mag_in;
   logic [CNT_W-1:0]         rem_ff, rem_in, dsr_ff, count_in;
   logic [STEP_W-1:0]        step_ff;
   logic                     neg_ff, neg_in;

   // output register
   logic                     out_chan_ff;
   logic signed [VAL_W-1:0]  out_avg_ff;
   logic [COUNT_W-1:0]       out_cnt_ff;

   logic [TPROD_W-1:0]       t_prod;
   logic [HPROD_W-1:0]       h_prod;
   logic signed [VAL_W:0]    t_val;

   logic [IDX_W-1:0]         slot;
   logic                     filled;
   logic [IDX_W:0]           slot_nxt;
   logic                     wrap;
   logic [ADDR_W-1:0]        ram_addr;
   logic [VAL_W-1:0]         ram_rdata;
   logic [VAL_W-1:0]         old_val;
   logic [CNT_W:0]           rem_sh;
   logic                     ge;

   // code conversion: one narrow multiply per channel, registered before use
   assign t_prod = TPROD_W'(code_ff) * TPROD_W'(TEMP_MUL);
   assign h_prod = HPROD_W'(code_ff) * HPROD_W'(HUMID_MUL);
   assign t_val  = $signed({1'b0, t_prod[TPROD_W-1:8]}) - (VAL_W+1)'(TEMP_OFS);
   assign value_in = (chan_ff == CH_HUMID) ? VAL_W'({1'b0, h_prod[HPROD_W-1:8]})
                                           : t_val[VAL_W-1:0];

   assign slot     = (chan_ff == CH_HUMID) ? hidx_ff : tidx_ff;
   assign filled   = (chan_ff == CH_HUMID) ? hfill_ff : tfill_ff;
   assign slot_nxt = {1'b0, slot} + (IDX_W+1)'(1);
   assign wrap     = (slot_nxt == (IDX_W+1)'(SAMPLES));
   assign ram_addr = (chan_ff == CH_HUMID) ? ADDR_W'(SAMPLES) + ADDR_W'(hidx_ff)
                                           : ADDR_W'(tidx_ff);

   scac_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (cmd.update),
      .addr  (ram_addr),
      .wdata (value_ff),
      .rdata (ram_rdata)
   );

   // before the first wrap the overwritten slot was never written: its value is taken as zero
   assign old_val = filled ? ram_rdata : '0;

   assign tsum_in = tsum_ff - TSUM_W'($signed(old_val)) + TSUM_W'(value_ff);
   assign hsum_in = hsum_ff - HSUM_W'(old_val[HVAL_W-1:0])
                            + HSUM_W'(value_ff[HVAL_W-1:0]);

   assign count_in = (filled || wrap) ? CNT_W'(SAMPLES) : CNT_W'(slot_nxt);

   always_comb begin
      if (chan_ff == CH_HUMID) begin
         neg_in = 1'b0;
         mag_in = MAG_W'(hsum_in);
      end else begin
         neg_in = tsum_in[TSUM_W-1];
         mag_in = neg_in ? MAG_W'(-tsum_in) : MAG_W'(tsum_in);
      end
   end

   // restoring division, one quotient bit per step
   assign rem_sh = {rem_ff, dvd_ff[MAG_W-1]};
   assign ge     = (rem_sh >= {1'b0, dsr_ff});
   assign rem_in = ge ? CNT_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[CNT_W-1:0];
   assign dvd_in = {dvd_ff[MAG_W-2:0], ge};

   assign sts.div_done = (step_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         chan_ff <= req_sensor_channel;
         code_ff <= req_raw_code;
      end
      if (cmd.read) begin
         value_ff <= value_in;
      end
      if (cmd.update) begin
         dvd_ff <= mag_in;
         rem_ff <= '0;
         dsr_ff <= count_in;
         neg_ff <= neg_in;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
      if (cmd.out_load) begin
         out_chan_ff <= chan_ff;
         out_avg_ff  <= neg_ff ? -dvd_ff[VAL_W-1:0] : dvd_ff[VAL_W-1:0];
         out_cnt_ff  <= COUNT_W'(dsr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tidx_ff  <= '0;
         hidx_ff  <= '0;
         tfill_ff <= 1'b0;
         hfill_ff <= 1'b0;
         tsum_ff  <= '0;
         hsum_ff  <= '0;
         step_ff  <= '0;
      end else begin
         if (cmd.update) begin
            step_ff <= STEP_W'(MAG_W);
            if (chan_ff == CH_HUMID) begin
               hidx_ff <= wrap ? '0 : slot_nxt[IDX_W-1:0];
               hfill_ff <= hfill_ff || wrap;
               hsum_ff <= hsum_in;
            end else begin
               tidx_ff <= wrap ? '0 : slot_nxt[IDX_W-1:0];
               tfill_ff <= tfill_ff || wrap;
               tsum_ff <= tsum_in;
            end
         end else if (cmd.div_step) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
   end

   assign rsp_result_channel = out_chan_ff;
   assign rsp_average_value  = out_avg_ff;
   assign rsp_samples_used   = out_cnt_ff;

endmodule

>>> rtl/core/sensor_code_convert_and_average.sv
// Sensor code converter with per-channel moving average (top level).
// Each accepted item is captured, converted while its ring slot is read, added to the sum
// and divided, one divider step per bit of the 16 + log2(SAMPLES) bit sum.
// A new item is accepted only once the serial divider has finished with the last one;
// the output register lets the next item start while a result waits.
// Synchronous active-high reset empties both rings and clears sums and indexes.
module sensor_code_convert_and_average
   import scac_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   scac_req_intf.sink         req_bus,
   scac_rsp_intf.source       rsp_bus
);

   scac_cmd_type cmd;
   scac_sts_type sts;

   scac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   scac_datapath #(
      .SAMPLES (SAMPLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_sensor_channel (req_bus.sensor_channel),
      .req_raw_code       (req_bus.raw_code),
      .rsp_result_channel (rsp_bus.result_channel),
      .rsp_average_value  (rsp_bus.average_value),
      .rsp_samples_used   (rsp_bus.samples_used)
   );

endmodule

>>> test/tb_top.sv
// Self-checking bench for sensor_code_convert_and_average: drives raw codes on
// req_bus, predicts the per-channel moving average and checks rsp_bus items.
// Depends on scac_pkg and the scac_req_intf / scac_rsp_intf interfaces.
module tb_top
   import scac_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSAMP      = SAMPLES_DEF;
   localparam int LATENCY    = 19 + $clog2(SAMPLES_DEF);
   localparam int CYCLE_MAX  = 500000;
   localparam int HOLD_LEN   = 400;

   typedef struct packed {
      logic               channel;
      logic [VAL_W-1:0]   average;
      logic [COUNT_W-1:0] count;
   } avg_result_type;

   logic clock = 1'b0;
   logic reset;

   scac_req_intf req_if ();
   scac_rsp_intf rsp_if ();

   sensor_code_convert_and_average DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if.sink),
      .rsp_bus (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, indexed by channel
   int ring_vals [2][NSAMP];
   int ring_slot [2];
   bit ring_full [2];
   int ring_sum  [2];

   avg_result_type avg_expected [$];

   int  sender_idle_pct = 0;
   int  recv_stall_pct  = 0;
   int  hold_req        = 0;
   int  hold_left       = 0;
   int  cycle_count     = 0;
   int  error_count     = 0;
   int  items_sent      = 0;
   int  results_seen    = 0;
   logic rand_channel   = CH_TEMP;

   task automatic clear_history();
      for (int c = 0; c < 2; c++) begin
         for (int i = 0; i < NSAMP; i++) ring_vals[c][i] = 0;
         ring_slot[c] = 0;
         ring_full[c] = 1'b0;
         ring_sum[c]  = 0;
      end
   endtask

   function automatic void predict_average(input logic ch, input logic [CODE_W-1:0] code);
      int value;
      int c;
      int count;
      int mean;
      avg_result_type res;
      c = (ch == CH_HUMID) ? 1 : 0;
      if (ch == CH_TEMP)
         value = ((int'(code) * TEMP_MUL) >>> 8) - TEMP_OFS;
      else
         value = (int'(code) * HUMID_MUL) >>> 8;
      ring_sum[c] = ring_sum[c] - ring_vals[c][ring_slot[c]] + value;
      ring_vals[c][ring_slot[c]] = value;
      ring_slot[c]++;
      if (ring_slot[c] >= NSAMP) begin
         ring_slot[c] = 0;
         ring_full[c] = 1'b1;
      end
      count = ring_full[c] ? NSAMP : ring_slot[c];
      if (count == 0) count = 1;
      mean = ring_sum[c] / count;   // truncates toward zero
      res.channel = ch;
      res.average = mean[VAL_W-1:0];
      res.count   = count[COUNT_W-1:0];
      avg_expected.push_back(res);
   endfunction

   // one item on req_bus; valid stays high on return
   task automatic send_item(input logic ch, input logic [CODE_W-1:0] code);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.sensor_channel <= ch;
      req_if.raw_code       <= code;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_average(ch, code);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (avg_expected.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus long hold-off when requested
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      avg_result_type want;
      cycle_count++;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (avg_expected.size() == 0) begin
            $display("%0t ERROR unexpected item: ch %0d avg %0d count %0d", $time,
                     rsp_if.result_channel, $signed(rsp_if.average_value),
                     rsp_if.samples_used);
            error_count++;
         end else begin
            want = avg_expected.pop_front();
            if (rsp_if.result_channel !== want.channel) begin
               $display("%0t ERROR result_channel: expected %0d, actual %0d", $time,
                        want.channel, rsp_if.result_channel);
               error_count++;
            end
            if (rsp_if.average_value !== want.average) begin
               $display("%0t ERROR average_value: expected %0d, actual %0d", $time,
                        $signed(want.average), $signed(rsp_if.average_value));
               error_count++;
            end
            if (rsp_if.samples_used !== want.count) begin
               $display("%0t ERROR samples_used: expected %0d, actual %0d", $time,
                        want.count, rsp_if.samples_used);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_MAX) @(posedge clock);
      $display("%0t timeout after %0d cycles, %0d items still expected", $time,
               cycle_count, avg_expected.size());
      $display("sensor_code_convert_and_average: mismatch");
      $finish;
   end

   // extremes, warm-up, wrap and replacement on both channels
   task automatic test_directed();
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      send_item(CH_TEMP, 16'h0000);
      send_item(CH_TEMP, 16'hFFFF);
      send_item(CH_HUMID, 16'hFFFF);
      send_item(CH_HUMID, 16'h0000);
      send_item(CH_TEMP, 16'h5555);
      send_item(CH_HUMID, 16'hAAAA);
      // small codes: negative sums that do not divide evenly, ring wraps
      for (int i = 0; i < 8; i++) send_item(CH_TEMP, CODE_W'(i * 3 + 1));
      for (int i = 0; i < 6; i++) send_item(CH_HUMID, 16'hFFFF ^ CODE_W'(i));
      send_item(CH_HUMID, 16'h0001);
      wait_for_results();
   endtask

   task automatic test_random_phase(input int n, input int s_idle, input int r_stall);
      logic [CODE_W-1:0] code;
      sender_idle_pct = s_idle;
      recv_stall_pct  = r_stall;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 30) rand_channel = ~rand_channel;
         case ($urandom_range(7))
            0:       code = $urandom_range(1) ? '1 : '0;
            1:       code = CODE_W'($urandom_range(255));
            2:       code = 16'hFF00 | CODE_W'($urandom_range(255));
            default: code = CODE_W'($urandom());
         endcase
         send_item(rand_channel, code);
      end
      wait_for_results();
   endtask

   // receiver holds off while items keep coming: the block fills and stalls req
   task automatic test_back_pressure();
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      hold_req = HOLD_LEN;
      for (int i = 0; i < 12; i++)
         send_item(($urandom_range(1) != 0) ? CH_HUMID : CH_TEMP, CODE_W'($urandom()));
      wait_for_results();
   endtask

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.sensor_channel = CH_TEMP;
      req_if.raw_code       = '0;
      clear_history();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(350, 0, 0);
      test_random_phase(250, 85, 0);
      test_random_phase(250, 0, 85);
      test_random_phase(300, 29, 29);
      test_back_pressure();

      wait_for_results();
      repeat (2 * LATENCY) @(posedge clock);
      $display("Sent %0d items on both channels, %0d results checked.", items_sent,
               results_seen);
      $display("Covered code extremes, warm-up, ring wrap, idle/stall mixes and back-pressure.");
      if (error_count == 0 && avg_expected.size() == 0)
         $display("sensor_code_convert_and_average: match");
      else
         $display("sensor_code_convert_and_average: mismatch");
      $finish;
   end

endmodule
